// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int CAU_DATA_WIDTH = 16;
   localparam int CAU_FRAC_BITS  = 8;

   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_MUL  = 2'd1,
      FUNC_DIV  = 2'd2,
      FUNC_CONJ = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIV0 = 2'd1,
      STATUS_SAT  = 2'd2,
      STATUS_RSVD = 2'd3
   } status_type;

   // Control that travels with an item down the pipeline
   typedef struct packed {
      logic     valid;
      func_type func;
      logic     div_zero;
      logic     neg_re;
      logic     neg_im;
      logic     ovf_re;
      logic     ovf_im;
      logic     sat;
   } ctrl_type;

endpackage

// ===== rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, multiply, divide and conjugate on signed fixed point operands.
// ----------------------------------------------------------------------------
// Takes one item in every cycle while busy is low. An item passes a product
// stage and a sum stage, then a row of DATA_WIDTH+FRAC_BITS+1 divider cells,
// each resolving one quotient bit of both result parts, and then the
// response register. Every operation takes the same path, so results leave
// in order. busy is high only during reset. rsp_valid marks a result for one
// cycle; the receiver must take it then.
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int DATA_WIDTH = CAU_DATA_WIDTH,
   parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_func,
   input  logic signed [DATA_WIDTH-1:0]   req_a_real,
   input  logic signed [DATA_WIDTH-1:0]   req_a_imag,
   input  logic signed [DATA_WIDTH-1:0]   req_b_real,
   input  logic signed [DATA_WIDTH-1:0]   req_b_imag,
   output logic                           rsp_valid,
   output logic signed [DATA_WIDTH-1:0]   rsp_res_real,
   output logic signed [DATA_WIDTH-1:0]   rsp_res_imag,
   output logic [1:0]                     rsp_status
);

   localparam int DW      = DATA_WIDTH;
   localparam int NQ      = DATA_WIDTH + FRAC_BITS + 1;
   localparam int LATENCY = NQ + 3;

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   ctrl_type        f_ctl;
   logic [DW-1:0]   f_pass_re, f_pass_im;
   logic [2*DW-1:0] f_mag_re, f_mag_im, f_den;

   cau_front #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_func    (func_type'(req_func)),
      .in_a_real  (req_a_real),
      .in_a_imag  (req_a_imag),
      .in_b_real  (req_b_real),
      .in_b_imag  (req_b_imag),
      .ctl_out    (f_ctl),
      .pass_re_out(f_pass_re),
      .pass_im_out(f_pass_im),
      .mag_re_out (f_mag_re),
      .mag_im_out (f_mag_im),
      .den_out    (f_den)
   );

   ctrl_type        c_ctl     [0:NQ];
   logic [2*DW-1:0] c_den     [0:NQ];
   logic [3*DW-1:0] c_rem_re  [0:NQ];
   logic [3*DW-1:0] c_rem_im  [0:NQ];
   logic [NQ-1:0]   c_q_re    [0:NQ];
   logic [NQ-1:0]   c_q_im    [0:NQ];
   logic [DW-1:0]   c_pass_re [0:NQ];
   logic [DW-1:0]   c_pass_im [0:NQ];

   // a quotient of 2^DATA_WIDTH or more saturates; flag it on entry
   always_comb begin
      c_ctl[0]        = f_ctl;
      c_ctl[0].ovf_re = {{DW{1'b0}}, f_mag_re} >= {f_den, {DW{1'b0}}};
      c_ctl[0].ovf_im = {{DW{1'b0}}, f_mag_im} >= {f_den, {DW{1'b0}}};
   end

   assign c_den[0]     = f_den;
   assign c_rem_re[0]  = {{DW{1'b0}}, f_mag_re};
   assign c_rem_im[0]  = {{DW{1'b0}}, f_mag_im};
   assign c_q_re[0]    = '0;
   assign c_q_im[0]    = '0;
   assign c_pass_re[0] = f_pass_re;
   assign c_pass_im[0] = f_pass_im;

   for (genvar k = 0; k < NQ; k++) begin : g_cell
      cau_div_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl_in     (c_ctl[k]),
         .den_in     (c_den[k]),
         .rem_re_in  (c_rem_re[k]),
         .rem_im_in  (c_rem_im[k]),
         .q_re_in    (c_q_re[k]),
         .q_im_in    (c_q_im[k]),
         .pass_re_in (c_pass_re[k]),
         .pass_im_in (c_pass_im[k]),
         .ctl_out    (c_ctl[k+1]),
         .den_out    (c_den[k+1]),
         .rem_re_out (c_rem_re[k+1]),
         .rem_im_out (c_rem_im[k+1]),
         .q_re_out   (c_q_re[k+1]),
         .q_im_out   (c_q_im[k+1]),
         .pass_re_out(c_pass_re[k+1]),
         .pass_im_out(c_pass_im[k+1])
      );
   end

   logic          p_valid;
   logic [DW-1:0] p_real, p_imag;
   status_type    p_status;

   cau_post #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (c_ctl[NQ]),
      .q_re_in   (c_q_re[NQ]),
      .q_im_in   (c_q_im[NQ]),
      .pass_re_in(c_pass_re[NQ]),
      .pass_im_in(c_pass_im[NQ]),
      .out_valid (p_valid),
      .out_real  (p_real),
      .out_imag  (p_imag),
      .out_status(p_status)
   );

   assign rsp_valid    = p_valid;
   assign rsp_res_real = $signed(p_real);
   assign rsp_res_imag = $signed(p_imag);
   assign rsp_status   = p_status;

   localparam logic [DW-1:0] MAXB = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINB = {1'b1, {(DW-1){1'b0}}};

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("transfer without a response at the expected cycle");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DIV0) |->
         (rsp_res_real == '0 && rsp_res_imag == '0))
      else $error("divide by zero with a nonzero result");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_SAT) |->
         ($unsigned(rsp_res_real) == MAXB || $unsigned(rsp_res_real) == MINB ||
          $unsigned(rsp_res_imag) == MAXB || $unsigned(rsp_res_imag) == MINB))
      else $error("saturation status without a clamped part");

endmodule

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Operand products, sums, rounding and saturation for add, multiply and
// conjugate; numerator magnitudes and denominator for divide.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
   parameter int DATA_WIDTH = CAU_DATA_WIDTH,
   parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  func_type                       in_func,
   input  logic signed [DATA_WIDTH-1:0]   in_a_real,
   input  logic signed [DATA_WIDTH-1:0]   in_a_imag,
   input  logic signed [DATA_WIDTH-1:0]   in_b_real,
   input  logic signed [DATA_WIDTH-1:0]   in_b_imag,
   output ctrl_type                       ctl_out,
   output logic [DATA_WIDTH-1:0]          pass_re_out,
   output logic [DATA_WIDTH-1:0]          pass_im_out,
   output logic [2*DATA_WIDTH-1:0]        mag_re_out,
   output logic [2*DATA_WIDTH-1:0]        mag_im_out,
   output logic [2*DATA_WIDTH-1:0]        den_out
);

   localparam int DW = DATA_WIDTH;
   localparam int PW = 2*DATA_WIDTH;
   localparam int VW = 2*DATA_WIDTH + 2;
   localparam logic signed [VW-1:0] MAXV = {{(VW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [VW-1:0] MINV = {{(VW-DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic [PW:0] HALF = {{(PW-FRAC_BITS+2){1'b0}}, {(FRAC_BITS-1){1'b0}}} |
                                  ((PW+1)'(1) << (FRAC_BITS-1));

   // saturate to DW bits; msb of the result is the saturation flag
   function automatic logic [DW:0] sat_fn(logic signed [VW-1:0] v);
      logic [DW:0] r;
      if (v > MAXV) begin
         r = {1'b1, MAXV[DW-1:0]};
      end else if (v < MINV) begin
         r = {1'b1, MINV[DW-1:0]};
      end else begin
         r = {1'b0, v[DW-1:0]};
      end
      return r;
   endfunction

   // stage 1
   logic                 v1_ff;
   func_type             func1_ff;
   logic                 bzero1_ff;
   logic signed [DW-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      func1_ff  <= in_func;
      bzero1_ff <= (in_b_real == '0) && (in_b_imag == '0);
      ar1_ff    <= in_a_real;
      ai1_ff    <= in_a_imag;
      br1_ff    <= in_b_real;
      bi1_ff    <= in_b_imag;
      p_rr_ff   <= PW'(in_a_real) * PW'(in_b_real);
      p_ii_ff   <= PW'(in_a_imag) * PW'(in_b_imag);
      p_ri_ff   <= PW'(in_a_real) * PW'(in_b_imag);
      p_ir_ff   <= PW'(in_a_imag) * PW'(in_b_real);
      sq_r_ff   <= PW'(in_b_real) * PW'(in_b_real);
      sq_i_ff   <= PW'(in_b_imag) * PW'(in_b_imag);
   end

   // stage 2
   logic signed [PW:0]   m_re, m_im, n_re, n_im;
   logic [PW:0]          mm_re, mm_im, rn_re, rn_im, an_re, an_im;
   logic signed [DW:0]   s_re, s_im, c_im;
   logic signed [VW-1:0] v_re, v_im;
   logic [DW:0]          o_re, o_im;
   ctrl_type             ctl_in;
   logic [PW-1:0]        den_in;

   always_comb begin
      m_re = $signed({p_rr_ff[PW-1], p_rr_ff}) - $signed({p_ii_ff[PW-1], p_ii_ff});
      m_im = $signed({p_ri_ff[PW-1], p_ri_ff}) + $signed({p_ir_ff[PW-1], p_ir_ff});
      n_re = $signed({p_rr_ff[PW-1], p_rr_ff}) + $signed({p_ii_ff[PW-1], p_ii_ff});
      n_im = $signed({p_ir_ff[PW-1], p_ir_ff}) - $signed({p_ri_ff[PW-1], p_ri_ff});
      mm_re = m_re[PW] ? $unsigned(-m_re) : $unsigned(m_re);
      mm_im = m_im[PW] ? $unsigned(-m_im) : $unsigned(m_im);
      rn_re = (mm_re + HALF) >> FRAC_BITS;
      rn_im = (mm_im + HALF) >> FRAC_BITS;
      an_re = n_re[PW] ? $unsigned(-n_re) : $unsigned(n_re);
      an_im = n_im[PW] ? $unsigned(-n_im) : $unsigned(n_im);
      s_re  = $signed({ar1_ff[DW-1], ar1_ff}) + $signed({br1_ff[DW-1], br1_ff});
      s_im  = $signed({ai1_ff[DW-1], ai1_ff}) + $signed({bi1_ff[DW-1], bi1_ff});
      c_im  = -$signed({ai1_ff[DW-1], ai1_ff});
      den_in = $unsigned(sq_r_ff) + $unsigned(sq_i_ff);

      case (func1_ff)
         FUNC_ADD: begin
            v_re = {{(VW-DW-1){s_re[DW]}}, s_re};
            v_im = {{(VW-DW-1){s_im[DW]}}, s_im};
         end
         FUNC_MUL: begin
            v_re = m_re[PW] ? -$signed({1'b0, rn_re}) : $signed({1'b0, rn_re});
            v_im = m_im[PW] ? -$signed({1'b0, rn_im}) : $signed({1'b0, rn_im});
         end
         default: begin
            v_re = {{(VW-DW){ar1_ff[DW-1]}}, ar1_ff};
            v_im = {{(VW-DW-1){c_im[DW]}}, c_im};
         end
      endcase
      o_re = sat_fn(v_re);
      o_im = sat_fn(v_im);

      ctl_in          = '0;
      ctl_in.valid    = v1_ff;
      ctl_in.func     = func1_ff;
      ctl_in.div_zero = bzero1_ff;
      ctl_in.neg_re   = n_re[PW];
      ctl_in.neg_im   = n_im[PW];
      ctl_in.sat      = o_re[DW] | o_im[DW];
   end

   ctrl_type      ctl_ff;
   logic [DW-1:0] pass_re_ff, pass_im_ff;
   logic [PW-1:0] mag_re_ff, mag_im_ff, den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      pass_re_ff <= o_re[DW-1:0];
      pass_im_ff <= o_im[DW-1:0];
      mag_re_ff  <= an_re[PW-1:0];
      mag_im_ff  <= an_im[PW-1:0];
      den_ff     <= den_in;
   end

   assign ctl_out     = ctl_ff;
   assign pass_re_out = pass_re_ff;
   assign pass_im_out = pass_im_ff;
   assign mag_re_out  = mag_re_ff;
   assign mag_im_out  = mag_im_ff;
   assign den_out     = den_ff;

endmodule

// ===== rtl/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell
// One quotient bit of the real and imaginary divisions per cell; the rest of
// the item rides along.
// ----------------------------------------------------------------------------
module cau_div_cell import cau_pkg::*; #(
   parameter int DATA_WIDTH = CAU_DATA_WIDTH,
   parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ctrl_type                            ctl_in,
   input  logic [2*DATA_WIDTH-1:0]             den_in,
   input  logic [3*DATA_WIDTH-1:0]             rem_re_in,
   input  logic [3*DATA_WIDTH-1:0]             rem_im_in,
   input  logic [DATA_WIDTH+FRAC_BITS:0]       q_re_in,
   input  logic [DATA_WIDTH+FRAC_BITS:0]       q_im_in,
   input  logic [DATA_WIDTH-1:0]               pass_re_in,
   input  logic [DATA_WIDTH-1:0]               pass_im_in,
   output ctrl_type                            ctl_out,
   output logic [2*DATA_WIDTH-1:0]             den_out,
   output logic [3*DATA_WIDTH-1:0]             rem_re_out,
   output logic [3*DATA_WIDTH-1:0]             rem_im_out,
   output logic [DATA_WIDTH+FRAC_BITS:0]       q_re_out,
   output logic [DATA_WIDTH+FRAC_BITS:0]       q_im_out,
   output logic [DATA_WIDTH-1:0]               pass_re_out,
   output logic [DATA_WIDTH-1:0]               pass_im_out
);

   localparam int DW = DATA_WIDTH;
   localparam int RW = 3*DATA_WIDTH;
   localparam int NQ = DATA_WIDTH + FRAC_BITS + 1;

   logic [RW-1:0] dsh;
   logic [RW:0]   r2_re, r2_im, d_re, d_im;
   logic          ge_re, ge_im;
   logic [RW-1:0] rem_re_in_n, rem_im_in_n;

   // double the remainder, subtract the shifted divisor where it fits
   always_comb begin
      dsh   = {den_in, {DW{1'b0}}};
      r2_re = {rem_re_in, 1'b0};
      r2_im = {rem_im_in, 1'b0};
      ge_re = r2_re >= {1'b0, dsh};
      ge_im = r2_im >= {1'b0, dsh};
      d_re  = r2_re - {1'b0, dsh};
      d_im  = r2_im - {1'b0, dsh};
      rem_re_in_n = ge_re ? d_re[RW-1:0] : r2_re[RW-1:0];
      rem_im_in_n = ge_im ? d_im[RW-1:0] : r2_im[RW-1:0];
   end

   ctrl_type      ctl_ff;
   logic [2*DW-1:0] den_ff;
   logic [RW-1:0] rem_re_ff, rem_im_ff;
   logic [NQ-1:0] q_re_ff, q_im_ff;
   logic [DW-1:0] pass_re_ff, pass_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      den_ff     <= den_in;
      rem_re_ff  <= rem_re_in_n;
      rem_im_ff  <= rem_im_in_n;
      q_re_ff    <= {q_re_in[NQ-2:0], ge_re};
      q_im_ff    <= {q_im_in[NQ-2:0], ge_im};
      pass_re_ff <= pass_re_in;
      pass_im_ff <= pass_im_in;
   end

   assign ctl_out     = ctl_ff;
   assign den_out     = den_ff;
   assign rem_re_out  = rem_re_ff;
   assign rem_im_out  = rem_im_ff;
   assign q_re_out    = q_re_ff;
   assign q_im_out    = q_im_ff;
   assign pass_re_out = pass_re_ff;
   assign pass_im_out = pass_im_ff;

endmodule

// ===== rtl/cau_post.sv =====
// ----------------------------------------------------------------------------
// cau_post
// Quotient rounding and saturation, result select and the response register.
// ----------------------------------------------------------------------------
module cau_post import cau_pkg::*; #(
   parameter int DATA_WIDTH = CAU_DATA_WIDTH,
   parameter int FRAC_BITS  = CAU_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ctrl_type                            ctl_in,
   input  logic [DATA_WIDTH+FRAC_BITS:0]       q_re_in,
   input  logic [DATA_WIDTH+FRAC_BITS:0]       q_im_in,
   input  logic [DATA_WIDTH-1:0]               pass_re_in,
   input  logic [DATA_WIDTH-1:0]               pass_im_in,
   output logic                                out_valid,
   output logic [DATA_WIDTH-1:0]               out_real,
   output logic [DATA_WIDTH-1:0]               out_imag,
   output status_type                          out_status
);

   localparam int DW = DATA_WIDTH;
   localparam int NQ = DATA_WIDTH + FRAC_BITS + 1;
   localparam logic [NQ-1:0] LIM = {{(NQ-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] MAXB = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINB = {1'b1, {(DW-1){1'b0}}};

   // round the quotient, clamp to the field; msb is the saturation flag
   function automatic logic [DW:0] qsat(logic [NQ-1:0] q, logic neg, logic ovf);
      logic [NQ:0]   rq;
      logic [NQ-1:0] mag;
      logic [NQ-1:0] nb;
      logic [DW:0]   r;
      rq  = {1'b0, q} + (NQ+1)'(1);
      mag = rq[NQ:1];
      nb  = -mag;
      if (ovf) begin
         r = {1'b1, neg ? MINB : MAXB};
      end else if (neg) begin
         r = (mag > LIM) ? {1'b1, MINB} : {1'b0, nb[DW-1:0]};
      end else begin
         r = (mag > LIM - NQ'(1)) ? {1'b1, MAXB} : {1'b0, mag[DW-1:0]};
      end
      return r;
   endfunction

   logic [DW:0]   d_re, d_im;
   logic [DW-1:0] re_in, im_in;
   status_type    st_in;

   always_comb begin
      d_re = qsat(q_re_in, ctl_in.neg_re, ctl_in.ovf_re);
      d_im = qsat(q_im_in, ctl_in.neg_im, ctl_in.ovf_im);
      if (ctl_in.func == FUNC_DIV) begin
         if (ctl_in.div_zero) begin
            re_in = '0;
            im_in = '0;
            st_in = STATUS_DIV0;
         end else begin
            re_in = d_re[DW-1:0];
            im_in = d_im[DW-1:0];
            st_in = (d_re[DW] | d_im[DW]) ? STATUS_SAT : STATUS_OK;
         end
      end else begin
         re_in = pass_re_in;
         im_in = pass_im_in;
         st_in = ctl_in.sat ? STATUS_SAT : STATUS_OK;
      end
   end

   logic          valid_ff;
   logic [DW-1:0] re_ff, im_ff;
   status_type    st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in.valid;
      end
      re_ff <= re_in;
      im_ff <= im_in;
      st_ff <= st_in;
   end

   assign out_valid  = valid_ff;
   assign out_real   = re_ff;
   assign out_imag   = im_ff;
   assign out_status = st_ff;

endmodule
